@@ hw/rtl/lrt_pkg.sv @@
// Shared types, codes and defaults for the LRU replacement tracker.
package lrt_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned STATUS_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_TOUCH  = 2'd1,
    OP_EVICT  = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TRACKED   = 2'd2,
    ST_UNTRACKED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CTL_IDLE,
    CTL_CHECK,
    CTL_W1,
    CTL_W2,
    CTL_W3,
    CTL_DONE
  } ctl_state_e;

  typedef enum logic [1:0] {
    STEP_NONE,
    STEP_W1,
    STEP_W2,
    STEP_W3
  } step_e;

  typedef struct packed {
    logic  accept;
    logic  check;
    step_e step;
    logic  commit;
  } lrt_cmd_t;

  typedef struct packed {
    logic work;
    logic out_free;
  } lrt_sts_t;

endpackage

@@ hw/rtl/lru_replacement_tracker.sv @@
// Top level of the LRU replacement tracker: sequencer, datapath and checks.
//
// Usage: one request channel (in_valid_i / in_stall_o, operation_i, slot_i) and
// one result channel (out_valid_o / out_stall_i, victim_slot_o, status_o).
// Operations: insert a slot at the newest end, touch a slot to move it to the
// newest end, evict the oldest slot. Every request gives exactly one result.
// Steps: accept, check, the link updates W1, W2 and W3, and commit; a request
// that rewrites no link (errors, no-op, touch of the newest slot) skips W1-W3.
// No new request is taken until the last one commits; the single write port
// of each link RAM is why the link updates are split over W1, W2 and W3.
// The request side stalls whenever the sequencer is not idle.
// When the receiver stalls, the result register holds its value; the next
// request is still accepted and worked on, and it waits at commit until the
// result register is taken.
// Reset clears the tracked bits and both list ends at once; no clearing pass
// is needed, link entries are only used for tracked slots.
module lru_replacement_tracker import lrt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [SLOT_W-1:0]   slot_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SLOT_W-1:0]   victim_slot_o,
  output logic [STATUS_W-1:0] status_o
);

  lrt_cmd_t cmd;
  lrt_sts_t sts;

  lrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrt_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (operation_i),
    .slot_i        (slot_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .victim_slot_o (victim_slot_o),
    .status_o      (status_o)
  );

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request side not stalled after accept");

  a_result_from_commit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.commit))
    else $error("result appeared without commit");

  a_commit_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("commit overwrote a stalled result");

  a_victim_only_on_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (victim_slot_o == '0))
    else $error("nonzero victim on failed request");

endmodule

@@ hw/rtl/lrt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lrt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lrt_ctrl.sv @@
// Sequencer for the LRU replacement tracker: accept, check, link writes, commit.
module lrt_ctrl import lrt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lrt_sts_t sts_i,
  output lrt_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.check  = 1'b0;
    cmd_o.step   = STEP_NONE;
    cmd_o.commit = 1'b0;
    case (state_q)
      CTL_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CTL_CHECK;
        end
      end
      CTL_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.work ? CTL_W1 : CTL_DONE;
      end
      CTL_W1: begin
        cmd_o.step = STEP_W1;
        state_d    = CTL_W2;
      end
      CTL_W2: begin
        cmd_o.step = STEP_W2;
        state_d    = CTL_W3;
      end
      CTL_W3: begin
        cmd_o.step = STEP_W3;
        state_d    = CTL_DONE;
      end
      CTL_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = CTL_IDLE;
        end
      end
      default: begin
        state_d = CTL_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != CTL_IDLE);

endmodule

@@ hw/rtl/lrt_datapath.sv @@
// Datapath for the LRU replacement tracker: link RAMs, ends, tracked bits, result register.
module lrt_datapath import lrt_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [OP_W-1:0]     operation_i,
  input  logic [SLOT_W-1:0]   slot_i,
  input  lrt_cmd_t            cmd_i,
  output lrt_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [SLOT_W-1:0]   victim_slot_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int unsigned IdxW  = $clog2(SLOTS);
  localparam int unsigned LinkW = $clog2(SLOTS + 1);
  localparam logic [LinkW-1:0] LinkNone = LinkW'(SLOTS);

  op_e                req_op_q;
  logic [SLOT_W-1:0]  req_slot_q;
  logic [LinkW-1:0]   oldest_q;
  logic [LinkW-1:0]   newest_q;
  logic [SLOTS-1:0]   tracked_q;
  status_e            chk_status_q;
  logic               work_q;
  logic               out_valid_q;
  logic [SLOT_W-1:0]  victim_q;
  status_e            out_status_q;

  logic [IdxW-1:0]    slot_idx;
  logic [LinkW-1:0]   slot_link;
  logic [IdxW-1:0]    oldest_idx;
  logic [IdxW-1:0]    newest_idx;
  logic               slot_ok;
  status_e            chk_status;
  logic               chk_work;

  logic [LinkW-1:0]   prev_rd;
  logic [LinkW-1:0]   next_rd;
  logic               prev_we;
  logic [IdxW-1:0]    prev_waddr;
  logic [LinkW-1:0]   prev_wdata;
  logic               next_we;
  logic [IdxW-1:0]    next_waddr;
  logic [LinkW-1:0]   next_wdata;
  logic [IdxW-1:0]    next_raddr;
  logic               out_free;

  assign slot_idx   = IdxW'(req_slot_q);
  assign slot_link  = LinkW'(req_slot_q);
  assign oldest_idx = IdxW'(oldest_q);
  assign newest_idx = IdxW'(newest_q);
  assign slot_ok    = (32'(req_slot_q) < SLOTS);

  always_comb begin
    chk_status = ST_OK;
    chk_work   = 1'b0;
    case (req_op_q)
      OP_INSERT: begin
        if (!slot_ok) begin
          chk_status = ST_UNTRACKED;
        end else if (tracked_q[slot_idx]) begin
          chk_status = ST_TRACKED;
        end else begin
          chk_work = 1'b1;
        end
      end
      OP_TOUCH: begin
        if (!slot_ok || !tracked_q[slot_idx]) begin
          chk_status = ST_UNTRACKED;
        end else begin
          chk_work = (slot_link != newest_q);
        end
      end
      OP_EVICT: begin
        if (oldest_q == LinkNone) begin
          chk_status = ST_EMPTY;
        end else begin
          chk_work = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign next_raddr = (req_op_q == OP_EVICT) ? oldest_idx : slot_idx;

  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = slot_idx;
    prev_wdata = LinkNone;
    next_we    = 1'b0;
    next_waddr = slot_idx;
    next_wdata = LinkNone;
    case (cmd_i.step)
      STEP_W1: begin
        case (req_op_q)
          OP_INSERT: begin
            prev_we    = 1'b1;
            prev_waddr = slot_idx;
            prev_wdata = newest_q;
            next_we    = 1'b1;
            next_waddr = slot_idx;
            next_wdata = LinkNone;
          end
          OP_TOUCH: begin
            prev_we    = (next_rd != LinkNone);
            prev_waddr = IdxW'(next_rd);
            prev_wdata = prev_rd;
            next_we    = (prev_rd != LinkNone);
            next_waddr = IdxW'(prev_rd);
            next_wdata = next_rd;
          end
          OP_EVICT: begin
            prev_we    = (next_rd != LinkNone);
            prev_waddr = IdxW'(next_rd);
            prev_wdata = LinkNone;
          end
          default: begin
          end
        endcase
      end
      STEP_W2: begin
        case (req_op_q)
          OP_INSERT: begin
            next_we    = (newest_q != LinkNone);
            next_waddr = newest_idx;
            next_wdata = slot_link;
          end
          OP_TOUCH: begin
            prev_we    = 1'b1;
            prev_waddr = slot_idx;
            prev_wdata = newest_q;
            next_we    = 1'b1;
            next_waddr = slot_idx;
            next_wdata = LinkNone;
          end
          default: begin
          end
        endcase
      end
      STEP_W3: begin
        if (req_op_q == OP_TOUCH) begin
          next_we    = 1'b1;
          next_waddr = newest_idx;
          next_wdata = slot_link;
        end
      end
      default: begin
      end
    endcase
  end

  lrt_ram #(
    .WIDTH (LinkW),
    .DEPTH (SLOTS)
  ) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .re_i    (cmd_i.check),
    .raddr_i (slot_idx),
    .rdata_o (prev_rd)
  );

  lrt_ram #(
    .WIDTH (LinkW),
    .DEPTH (SLOTS)
  ) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .re_i    (cmd_i.check),
    .raddr_i (next_raddr),
    .rdata_o (next_rd)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_op_q   <= op_e'(operation_i);
      req_slot_q <= slot_i;
    end
    if (cmd_i.check) begin
      chk_status_q <= chk_status;
      work_q       <= chk_work;
    end
    if (cmd_i.commit) begin
      out_status_q <= chk_status_q;
      victim_q     <= (work_q && (req_op_q == OP_EVICT)) ? SLOT_W'(oldest_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q   <= '0;
      oldest_q    <= LinkNone;
      newest_q    <= LinkNone;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
        if (work_q) begin
          case (req_op_q)
            OP_INSERT: begin
              tracked_q[slot_idx] <= 1'b1;
              if (newest_q == LinkNone) begin
                oldest_q <= slot_link;
              end
              newest_q <= slot_link;
            end
            OP_TOUCH: begin
              if (slot_link == oldest_q) begin
                oldest_q <= next_rd;
              end
              newest_q <= slot_link;
            end
            OP_EVICT: begin
              tracked_q[oldest_idx] <= 1'b0;
              if (next_rd != LinkNone) begin
                oldest_q <= next_rd;
              end else begin
                oldest_q <= LinkNone;
                newest_q <= LinkNone;
              end
            end
            default: begin
            end
          endcase
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free       = !out_valid_q || !out_stall_i;
  assign sts_o.work     = chk_work;
  assign sts_o.out_free = out_free;

  assign out_valid_o   = out_valid_q;
  assign victim_slot_o = victim_q;
  assign status_o      = out_status_q;

endmodule
